[design/bth_pkg.sv]
// shared types for the boundary tag heap allocator
`default_nettype none
package bth_pkg;
  typedef struct packed {
    logic        func;
    logic [15:0] req_bytes;
    logic [14:0] free_addr;
  } bth_in_t;

  typedef struct packed {
    logic [14:0] result_addr;
    logic [1:0]  status;
  } bth_out_t;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  localparam logic [1:0] REG_FIT_MODE  = 2'd0;
  localparam logic [1:0] REG_GROW_THR  = 2'd1;
  localparam logic [1:0] REG_GROW_PAD  = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;
endpackage
`default_nettype wire

[design/bth_tag_ram.sv]
// tag store: one write port, one registered read port
`default_nettype none
module bth_tag_ram #(
  parameter int DEPTH = 4096,
  parameter int AW = 12,
  parameter int DW = 18
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/boundary_tag_heap_allocator.sv]
// boundary tag heap allocator top level
//
//  channel | signals                       | beat taken when
//  --------+-------------------------------+-------------------------
//  request | start, busy, req (bth_in_t)   | start && !busy
//  result  | done, res (bth_out_t)         | done (one cycle, no stall)
//  config  | cfg_we, cfg_index, cfg_data   | cfg_we
//
// an allocate reads a tag for each block passed on the walk, runs the fit
// test, makes the two or four tag writes and gives the result beat. a free
// checks header, footer and both neighbours, writes the freed block's two
// tags and gives the result; a rejected address goes straight to the result.
// reset clears every tag word, then writes the initial block, with busy high.
// the receiver cannot stall: done is high for one cycle per request.
`default_nettype none
module boundary_tag_heap_allocator #(
  parameter int HEAP_WORDS = 4096,
  parameter int INIT_WORDS = 512
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire bth_pkg::bth_in_t req,
  output logic                  done,
  output bth_pkg::bth_out_t     res,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [15:0]      cfg_data
);
  localparam int AW = $clog2(HEAP_WORDS);
  // wide enough for the largest request size in words as well as the heap
  localparam int WW = (($clog2(HEAP_WORDS + 1) > 14) ? $clog2(HEAP_WORDS + 1) : 14) + 1;
  localparam int TW = WW + 1;
  localparam int IW = (INIT_WORDS > HEAP_WORDS) ? HEAP_WORDS : INIT_WORDS;
  localparam logic [WW-1:0] HEAP_W = WW'(HEAP_WORDS);
  localparam logic [WW-1:0] INIT_W = WW'(IW);

  typedef enum logic [4:0] {
    S_CLEAR, S_INIT_H, S_INIT_F, S_IDLE,
    S_WALK_RD, S_WALK_CHK, S_PLACE_A, S_PLACE_B, S_PLACE_C, S_PLACE_D,
    S_F_HDR, S_F_HCHK, S_F_FCHK, S_F_NCHK, S_F_PCHK, S_F_WA, S_F_WB, S_RESP
  } state_t;

  state_t state;
  logic fit_mode;
  logic [15:0] grow_thr, grow_pad;
  logic [WW-1:0] heap_top, search_pt, p, need, blk, excess, w, sz, start_w, total;
  logic [TW-1:0] hdr;
  logic [AW:0] clr;
  logic [14:0] addr_out;
  logic [1:0] status_out;
  logic is_done;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [TW-1:0] ram_wdata, ram_rdata;
  logic [WW-1:0] raddr_full;
  logic rd_oob, rd_oob_q;
  logic [TW-1:0] tag;

  logic [WW-1:0] fa_w;
  assign fa_w = WW'(req.free_addr[14:3]) - 1'b1;

  bth_tag_ram #(.DEPTH(HEAP_WORDS), .AW(AW), .DW(TW)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign rd_oob = raddr_full >= HEAP_W;
  assign ram_raddr = raddr_full[AW-1:0];
  assign tag = rd_oob_q ? '0 : ram_rdata;

  // write port driven per state
  logic [WW-1:0] wr_addr;
  logic [TW-1:0] wr_data;
  logic wr_en;
  always_comb begin
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = WW'(clr);
      end
      S_INIT_H: begin
        wr_en = 1'b1;
        wr_data = {INIT_W, 1'b0};
      end
      S_INIT_F: begin
        wr_en = 1'b1;
        wr_addr = INIT_W - 1'b1;
        wr_data = {INIT_W, 1'b0};
      end
      S_PLACE_A: begin
        wr_en = 1'b1;
        wr_addr = p;
        wr_data = (excess <= 4) ? {blk, 1'b1} : {need, 1'b1};
      end
      S_PLACE_B: begin
        wr_en = 1'b1;
        wr_addr = (excess <= 4) ? p + blk - 1'b1 : p + need - 1'b1;
        wr_data = (excess <= 4) ? {blk, 1'b1} : {need, 1'b1};
      end
      S_PLACE_C: begin
        wr_en = 1'b1;
        wr_addr = p + need;
        wr_data = {excess, 1'b0};
      end
      S_PLACE_D: begin
        wr_en = 1'b1;
        wr_addr = p + need + excess - 1'b1;
        wr_data = {excess, 1'b0};
      end
      S_F_WA: begin
        wr_en = 1'b1;
        wr_addr = start_w;
        wr_data = {total, 1'b0};
      end
      S_F_WB: begin
        wr_en = 1'b1;
        wr_addr = start_w + total - 1'b1;
        wr_data = {total, 1'b0};
      end
      default: ;
    endcase
  end
  assign ram_we = wr_en && (wr_addr < HEAP_W);
  assign ram_waddr = wr_addr[AW-1:0];
  assign ram_wdata = wr_data;

  always_comb begin
    case (state)
      S_IDLE:    raddr_full = (req.func == bth_pkg::FUNC_FREE) ? fa_w :
                              (fit_mode ? '0 : search_pt);
      S_WALK_CHK: raddr_full = p + tag[TW-1:1];
      S_F_HDR:   raddr_full = w;
      S_F_HCHK:  raddr_full = w + tag[TW-1:1] - 1'b1;
      S_F_FCHK:  raddr_full = w + sz;
      S_F_NCHK:  raddr_full = w - 1'b1;
      default:   raddr_full = p;
    endcase
  end

  logic [WW-1:0] pw, need_c;
  always_comb begin
    pw = WW'((17'(req.req_bytes) + 17'd7) >> 3);
    if (pw < 2) pw = WW'(2);
    need_c = pw + WW'(2);
  end

  logic [WW-1:0] ts;
  assign ts = tag[TW-1:1];
  logic [WW+3:0] need_b;
  assign need_b = {1'b0, need, 3'b000};

  // growth at the top, summed one bit wider so a huge request cannot wrap
  logic [WW-1:0] grow_ex;
  logic [WW:0] grow_sum;
  assign grow_ex = (need_b < (WW+4)'(grow_thr)) ? WW'(grow_pad[15:3]) : '0;
  assign grow_sum = {1'b0, heap_top} + {1'b0, need} + {1'b0, grow_ex};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      fit_mode <= 1'b0;
      grow_thr <= 16'd256;
      grow_pad <= 16'd256;
      heap_top <= INIT_W;
      search_pt <= '0;
      is_done <= 1'b0;
      rd_oob_q <= 1'b0;
    end else begin
      rd_oob_q <= rd_oob;
      is_done <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          bth_pkg::REG_FIT_MODE: fit_mode <= cfg_data[0];
          bth_pkg::REG_GROW_THR: grow_thr <= cfg_data;
          bth_pkg::REG_GROW_PAD: grow_pad <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (AW+1)'(HEAP_WORDS - 1)) state <= S_INIT_H;
        end
        S_INIT_H: state <= S_INIT_F;
        S_INIT_F: state <= S_IDLE;
        S_IDLE: if (start) begin
          addr_out <= '0;
          status_out <= bth_pkg::ST_DONE;
          if (req.func == bth_pkg::FUNC_FREE) begin
            w <= fa_w;
            if (req.free_addr == '0 || req.free_addr[2:0] != 3'd0 || fa_w >= heap_top)
              state <= S_RESP;
            else
              state <= S_F_HDR;
          end else if (req.req_bytes == '0) begin
            status_out <= bth_pkg::ST_ZERO;
            state <= S_RESP;
          end else begin
            need <= need_c;
            p <= fit_mode ? '0 : search_pt;
            state <= (fit_mode ? '0 : search_pt) < heap_top ? S_WALK_CHK : S_WALK_RD;
          end
        end
        S_WALK_RD: begin
          // p at or past top: grow
          if (p >= heap_top) begin
            p <= heap_top;
            excess <= grow_ex;
            blk <= need + grow_ex;
            if (grow_sum > {1'b0, HEAP_W}) begin
              status_out <= bth_pkg::ST_OOM;
              state <= S_RESP;
            end else begin
              heap_top <= grow_sum[WW-1:0];
              state <= S_PLACE_A;
            end
          end else begin
            state <= S_WALK_CHK;
          end
        end
        S_WALK_CHK: begin
          if (ts == '0) begin
            p <= heap_top;
            state <= S_WALK_RD;
          end else if (!tag[0] && ts >= need) begin
            blk <= ts;
            excess <= ts - need;
            state <= S_PLACE_A;
          end else begin
            p <= p + ts;
            state <= S_WALK_RD;
          end
        end
        S_PLACE_A: state <= S_PLACE_B;
        S_PLACE_B: begin
          addr_out <= 15'({p + 1'b1, 3'b000});
          state <= (excess <= 4) ? S_RESP : S_PLACE_C;
        end
        S_PLACE_C: state <= S_PLACE_D;
        S_PLACE_D: state <= S_RESP;
        S_F_HDR: state <= S_F_HCHK;
        S_F_HCHK: begin
          hdr <= tag;
          sz <= ts;
          if (!tag[0] || ts == '0 || w + ts > heap_top) state <= S_RESP;
          else state <= S_F_FCHK;
        end
        S_F_FCHK: begin
          start_w <= w;
          total <= sz;
          if (tag != hdr) state <= S_RESP;
          else state <= S_F_NCHK;
        end
        S_F_NCHK: begin
          if (w + sz < heap_top && !tag[0] && ts != '0 && w + sz + ts <= heap_top)
            total <= total + ts;
          state <= S_F_PCHK;
        end
        S_F_PCHK: begin
          if (w != '0 && !tag[0] && ts != '0 && ts <= w) begin
            start_w <= w - ts;
            total <= total + ts;
          end
          state <= S_F_WA;
        end
        S_F_WA: state <= S_F_WB;
        S_F_WB: begin
          search_pt <= start_w;
          state <= S_RESP;
        end
        S_RESP: begin
          is_done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);
  assign done = is_done;
  assign res.result_addr = addr_out;
  assign res.status = status_out;

  a_top_bound: assert property (@(posedge clk) disable iff (rst) heap_top <= HEAP_W)
    else $error("heap top past capacity");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> state == S_IDLE)
    else $error("result beat outside idle");
  a_oom_null: assert property (@(posedge clk) disable iff (rst)
    done && res.status != bth_pkg::ST_DONE |-> res.result_addr == '0)
    else $error("failed request with address");
endmodule
`default_nettype wire
